[rtl/bounded_transposition_edit_distance_core_defines.svh]
// Assertion macros shared by the edit distance core.
// Depends on nothing; the including module must provide clk and rst.
`ifndef BOUNDED_TRANSPOSITION_EDIT_DISTANCE_CORE_DEFINES_SVH
`define BOUNDED_TRANSPOSITION_EDIT_DISTANCE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BTED_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("edit distance core: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BTED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("edit distance core: next-cycle check failed");

`endif

[rtl/bted_pkg.sv]
// Shared constants, request codes and payload types of the edit distance core.
// Depends on nothing.
package bted_pkg;

  localparam int MAX_LEN = 64;
  // Bits of a length or a DP cell, 0..MAX_LEN.
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  // Bits of a target memory address, 0..MAX_LEN-1.
  localparam int TADDR_W = $clog2(MAX_LEN);
  localparam int CHAR_W = 16;
  localparam int DIST_W = 7;
  localparam int BOUND_W = 4;
  localparam logic [BOUND_W-1:0] BOUND_RESET = 4'd2;

  localparam logic [1:0] REQ_TARGET = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_END    = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CHAR_W-1:0] char_code;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              within_limit;
    logic              length_overflow;
  } result_t;

  // One entry of the row memory: the row two back and the row one back.
  typedef struct packed {
    logic [LEN_W-1:0] prev2;
    logic [LEN_W-1:0] prev;
  } row_t;

endpackage

[rtl/bounded_transposition_edit_distance_core.sv]
// Edit distance core: each query character starts a row sweep that reads one
// row memory entry per cycle. An end transaction's result is valid in the
// cycle after it is accepted. A new transaction is taken outside a sweep,
// while the result register is empty or drained.
// Reset (rst, synchronous): lengths, flags and the sweep control clear and
// max_dist returns to 2; the target and row memories are not cleared.
`include "bounded_transposition_edit_distance_core_defines.svh"

module bounded_transposition_edit_distance_core
  import bted_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result,
  input  logic               cfg_we,
  input  logic [BOUND_W-1:0] cfg_wdata
);

  localparam int D_W = (LEN_W > DIST_W) ? LEN_W : DIST_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ROW  = 1'b1;

  // Memories and their registered read ports.
  logic [CHAR_W-1:0] tchar_mem [MAX_LEN];
  row_t              row_mem   [MAX_LEN + 1];
  logic [CHAR_W-1:0] tchar_q;
  row_t              row_q;
  logic              tchar_re;
  logic [TADDR_W-1:0] tchar_raddr;
  logic              tchar_we;
  logic              row_re;
  logic [LEN_W-1:0]  row_raddr;
  logic              row_we;
  row_t              row_wdata;

  // Control and per-pair state.
  logic              state;
  logic [BOUND_W-1:0] max_dist;
  logic [LEN_W-1:0]  target_len;
  logic [LEN_W-1:0]  query_len;
  logic [CHAR_W-1:0] last_query_char;
  logic              bound_exceeded;
  logic              overflow_seen;
  logic [LEN_W-1:0]  final_cell;

  // Sweep registers.
  logic [LEN_W-1:0]  col;
  logic [LEN_W-1:0]  tl_q;
  logic [LEN_W-1:0]  i_q;
  logic [CHAR_W-1:0] c_q;
  logic              seed_q;
  logic [LEN_W-1:0]  prev_d1;
  logic [LEN_W-1:0]  prev2_d1;
  logic [LEN_W-1:0]  prev2_d2;
  logic [CHAR_W-1:0] t_d1;
  logic [LEN_W-1:0]  curr_prev;
  logic [LEN_W-1:0]  mn;

  logic              accept;
  logic              acc_target;
  logic              acc_query;
  logic              acc_end;
  logic              last_col;

  assign item_ready = (state == ST_IDLE) && (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;
  assign acc_target = accept && (item.req_type == REQ_TARGET);
  assign acc_query  = accept && (item.req_type == REQ_QUERY) && (query_len < LEN_W'(MAX_LEN));
  assign acc_end    = accept && (item.req_type == REQ_END);
  assign last_col   = (state == ST_ROW) && (col == tl_q);

  // Cell computation for the column whose memory data arrives this cycle.
  logic [LEN_W-1:0] prev_j;
  logic [LEN_W-1:0] prev2_j;
  logic [LEN_W:0]   cand_up;
  logic [LEN_W:0]   cand_left;
  logic [LEN_W:0]   cand_diag;
  logic [LEN_W:0]   cand_swap;
  logic [LEN_W:0]   v_wide;
  logic [LEN_W-1:0] v;
  logic [LEN_W-1:0] mn_fin;
  logic             cost;
  logic             swap_ok;

  always_comb begin
    prev_j    = seed_q ? col : row_q.prev;
    prev2_j   = seed_q ? '0 : row_q.prev2;
    cost      = (c_q != tchar_q);
    cand_up   = {1'b0, prev_j} + 1'b1;
    cand_left = {1'b0, curr_prev} + 1'b1;
    cand_diag = {1'b0, prev_d1} + {{LEN_W{1'b0}}, cost};
    cand_swap = {1'b0, prev2_d2} + 1'b1;
    swap_ok   = !seed_q && (col > LEN_W'(1)) && (c_q == t_d1) && (last_query_char == tchar_q);
    v_wide    = cand_up;
    if (cand_left < v_wide) v_wide = cand_left;
    if (cand_diag < v_wide) v_wide = cand_diag;
    if (swap_ok && (cand_swap < v_wide)) v_wide = cand_swap;
    if (col == '0) begin
      v = i_q;
    end else begin
      v = v_wide[LEN_W-1:0];
    end
    if ((col == '0) || (v < mn)) begin
      mn_fin = v;
    end else begin
      mn_fin = mn;
    end
  end

  // Memory port control. A row entry is written in the cycle after its read,
  // while the next entry is read, so the two never meet on one address.
  always_comb begin
    tchar_we    = acc_target && (query_len == '0) && (target_len < LEN_W'(MAX_LEN));
    row_re      = 1'b0;
    row_raddr   = '0;
    tchar_re    = 1'b0;
    tchar_raddr = '0;
    if (acc_query) begin
      row_re = 1'b1;
    end else if ((state == ST_ROW) && (col < tl_q)) begin
      row_re      = 1'b1;
      row_raddr   = col + 1'b1;
      tchar_re    = 1'b1;
      tchar_raddr = col[TADDR_W-1:0];
    end
    row_we    = (state == ST_ROW);
    row_wdata = '{prev2: prev_j, prev: v};
  end

  // Target character memory.
  always_ff @(posedge clk) begin
    if (tchar_we) tchar_mem[target_len[TADDR_W-1:0]] <= item.char_code;
    if (tchar_re) tchar_q <= tchar_mem[tchar_raddr];
  end

  // Row memory.
  always_ff @(posedge clk) begin
    if (row_we) row_mem[col] <= row_wdata;
    if (row_re) row_q <= row_mem[row_raddr];
  end

  // Sweep datapath registers.
  always_ff @(posedge clk) begin
    if (acc_query) begin
      c_q    <= item.char_code;
      tl_q   <= target_len;
      i_q    <= query_len + 1'b1;
      seed_q <= (query_len == '0);
    end
    if (state == ST_ROW) begin
      prev_d1   <= prev_j;
      prev2_d1  <= prev2_j;
      prev2_d2  <= prev2_d1;
      t_d1      <= tchar_q;
      curr_prev <= v;
      mn        <= mn_fin;
    end
    if (last_col) final_cell <= v;
  end

  // Distance of the finished pair.
  logic [LEN_W-1:0] diff;
  logic [D_W-1:0]   d;

  always_comb begin
    diff = (query_len > target_len) ? (query_len - target_len) : (target_len - query_len);
    if ((D_W'(diff) > D_W'(max_dist)) || bound_exceeded) begin
      d = D_W'(max_dist) + 1'b1;
    end else if (query_len == '0) begin
      d = D_W'(target_len);
    end else begin
      d = D_W'(final_cell);
    end
  end

  // Control state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      col             <= '0;
      max_dist        <= BOUND_RESET;
      target_len      <= '0;
      query_len       <= '0;
      last_query_char <= '0;
      bound_exceeded  <= 1'b0;
      overflow_seen   <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (cfg_we) max_dist <= cfg_wdata;
      if (result_valid && result_ready && !acc_end) result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            case (item.req_type)
              REQ_TARGET: begin
                if (query_len == '0) begin
                  if (target_len < LEN_W'(MAX_LEN)) begin
                    target_len <= target_len + 1'b1;
                  end else begin
                    overflow_seen <= 1'b1;
                  end
                end
              end
              REQ_QUERY: begin
                if (query_len < LEN_W'(MAX_LEN)) begin
                  state <= ST_ROW;
                  col   <= '0;
                end else begin
                  overflow_seen <= 1'b1;
                end
              end
              REQ_END: begin
                result_valid           <= 1'b1;
                result.distance        <= (d > D_W'(127)) ? DIST_W'(127) : d[DIST_W-1:0];
                result.within_limit    <= (d <= D_W'(max_dist));
                result.length_overflow <= overflow_seen;
                target_len      <= '0;
                query_len       <= '0;
                last_query_char <= '0;
                bound_exceeded  <= 1'b0;
                overflow_seen   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ROW: begin
          if (col == tl_q) begin
            state           <= ST_IDLE;
            query_len       <= i_q;
            last_query_char <= c_q;
            if (D_W'(mn_fin) > D_W'(max_dist)) bound_exceeded <= 1'b1;
          end else begin
            col <= col + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks on the sweep and the result path.
  `BTED_ASSERT_IMPL(a_col_in_row, state == ST_ROW, col <= tl_q)
  `BTED_ASSERT_NEXT(a_end_gives_result, acc_end, result_valid)
  `BTED_ASSERT_NEXT(a_row_adds_query, last_col, query_len == $past(query_len) + 1'b1)
  `BTED_ASSERT_IMPL(a_len_bound, 1'b1, (query_len <= LEN_W'(MAX_LEN)) && (target_len <= LEN_W'(MAX_LEN)))

endmodule

[sim/tb_bounded_transposition_edit_distance_core.sv]
// Self-checking testbench for the bounded transposition edit distance core.
// It predicts each result on its own and checks every result transaction.
// It depends on bted_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_bounded_transposition_edit_distance_core;
  import bted_pkg::*;

  // Request code that the core ignores.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Kinds of overlong pair that open a random phase.
  localparam int OVF_NONE   = 0;
  localparam int OVF_TARGET = 1;
  localparam int OVF_QUERY  = 2;

  // Cycles the receiver holds off once to back the core up.
  localparam int LONG_HOLD = 400;
  // Cycles the longest row sweep can still run after the last result.
  localparam int SWEEP_TAIL = 80;
  localparam int PHASE_ITEMS = 90;

  typedef enum int {EDIT_SUB, EDIT_SWAP, EDIT_DEL, EDIT_INS} edit_e;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  item_t              item = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  result_t            result;
  logic               cfg_we = 1'b0;
  logic [BOUND_W-1:0] cfg_wdata = '0;

  // Transactions waiting to be offered, and distances still to come back.
  item_t   pending_items[$];
  result_t expected_distances[$];

  // Shadow state of the distance computation.
  logic [CHAR_W-1:0]  tgt_chars [MAX_LEN];
  logic [LEN_W-1:0]   row_prev  [MAX_LEN+1];
  logic [LEN_W-1:0]   row_prev2 [MAX_LEN+1];
  logic [LEN_W-1:0]   row_curr  [MAX_LEN+1];
  int                 tgt_len = 0;
  int                 qry_len = 0;
  logic [CHAR_W-1:0]  last_qchar = '0;
  bit                 bound_hit = 1'b0;
  bit                 ovf_seen = 1'b0;
  logic [BOUND_W-1:0] bound_cfg = BOUND_RESET;

  int mismatches = 0;
  int results_seen = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  bounded_transposition_edit_distance_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic item_t mk_item(input logic [1:0] req, input logic [CHAR_W-1:0] ch);
    item_t it;
    it.req_type = req;
    it.char_code = ch;
    return it;
  endfunction

  // Apply one accepted transaction to the shadow state; an end of pair
  // queues the distance it should produce.
  task automatic edit_distance_step(input item_t it);
    int      i;
    int      j;
    int      v;
    int      t;
    int      mn;
    int      cost;
    int      gap;
    result_t r;
    case (it.req_type)
      REQ_TARGET: begin
        // Target characters count only before the first query character.
        if (qry_len == 0) begin
          if (tgt_len >= MAX_LEN) begin
            ovf_seen = 1'b1;
          end else begin
            tgt_chars[tgt_len] = it.char_code;
            tgt_len++;
          end
        end
      end
      REQ_QUERY: begin
        if (qry_len >= MAX_LEN) begin
          ovf_seen = 1'b1;
        end else begin
          if (qry_len == 0) begin
            for (j = 0; j <= tgt_len; j++) begin
              row_prev[j] = LEN_W'(j);
              row_prev2[j] = '0;
            end
          end
          i = qry_len + 1;
          row_curr[0] = LEN_W'(i);
          mn = i;
          for (j = 1; j <= tgt_len; j++) begin
            cost = (it.char_code == tgt_chars[j-1]) ? 0 : 1;
            v = int'(row_prev[j]) + 1;
            t = int'(row_curr[j-1]) + 1;
            if (t < v) v = t;
            t = int'(row_prev[j-1]) + cost;
            if (t < v) v = t;
            // Swap of two adjacent characters.
            if (i > 1 && j > 1 && it.char_code == tgt_chars[j-2] &&
                last_qchar == tgt_chars[j-1]) begin
              t = int'(row_prev2[j-2]) + 1;
              if (t < v) v = t;
            end
            row_curr[j] = LEN_W'(v);
            if (v < mn) mn = v;
          end
          if (mn > int'(bound_cfg)) bound_hit = 1'b1;
          row_prev2 = row_prev;
          row_prev = row_curr;
          last_qchar = it.char_code;
          qry_len = i;
        end
      end
      REQ_END: begin
        gap = (qry_len > tgt_len) ? qry_len - tgt_len : tgt_len - qry_len;
        if (gap > int'(bound_cfg) || bound_hit) v = int'(bound_cfg) + 1;
        else if (qry_len == 0) v = tgt_len;
        else v = int'(row_prev[tgt_len]);
        if (v > 127) v = 127;
        r.distance = DIST_W'(v);
        r.within_limit = (v <= int'(bound_cfg));
        r.length_overflow = ovf_seen;
        expected_distances.push_back(r);
        tgt_len = 0;
        qry_len = 0;
        last_qchar = '0;
        bound_hit = 1'b0;
        ovf_seen = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: result %0d: %s: got %0d, expected %0d",
             $time, results_seen, what, got, want);
  endtask

  // Driver: predicts on acceptance and offers the next pending transaction.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        edit_distance_step(item);
      end
      if (!item_valid || item_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction and paces result_ready.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_distances.size() == 0) begin
          report_mismatch("result with nothing expected", int'(result.distance), -1);
        end else begin
          want = expected_distances.pop_front();
          if (result.distance !== want.distance)
            report_mismatch("distance", int'(result.distance), int'(want.distance));
          if (result.within_limit !== want.within_limit)
            report_mismatch("within_limit", int'(result.within_limit),
                            int'(want.within_limit));
          if (result.length_overflow !== want.length_overflow)
            report_mismatch("length_overflow", int'(result.length_overflow),
                            int'(want.length_overflow));
        end
      end
      // One long hold-off while plenty of input is still queued.
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 10 && pending_items.size() > 20) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Wait until every transaction is taken and every result is back, then
  // give a row sweep time to finish.
  task automatic settle_idle();
    while (pending_items.size() != 0 || item_valid || expected_distances.size() != 0)
      @(posedge clk);
    repeat (SWEEP_TAIL) @(posedge clk);
  endtask

  task automatic write_max_dist(input logic [BOUND_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    bound_cfg = v;
  endtask

  // Queue one pair: a target, a query derived from it by a few edits, and
  // the end transaction. Stray requests are mixed into the query at times.
  task automatic queue_pair(input int tgt_n, input int qry_n, input int edits,
                            input bit wild, inout int n_items);
    logic [CHAR_W-1:0] tgt[$];
    logic [CHAR_W-1:0] qry[$];
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] tmp;
    int                k;
    int                pos;
    base = CHAR_W'($urandom);
    for (k = 0; k < tgt_n; k++)
      tgt.push_back(wild ? CHAR_W'($urandom) : base + CHAR_W'($urandom_range(3)));
    for (k = 0; k < qry_n; k++)
      qry.push_back(k < tgt_n ? tgt[k] : base + CHAR_W'($urandom_range(3)));
    for (k = 0; k < edits; k++) begin
      pos = (qry.size() > 1) ? $urandom_range(qry.size() - 1) : 0;
      case (edit_e'($urandom_range(3)))
        EDIT_SUB: if (qry.size() > 0) qry[pos] = base + CHAR_W'($urandom_range(3));
        EDIT_SWAP: begin
          if (pos + 1 < qry.size()) begin
            tmp = qry[pos];
            qry[pos] = qry[pos+1];
            qry[pos+1] = tmp;
          end
        end
        EDIT_DEL: if (qry.size() > 0) qry.delete(pos);
        default: qry.insert(pos, base + CHAR_W'($urandom_range(3)));
      endcase
    end
    for (k = 0; k < tgt.size(); k++)
      pending_items.push_back(mk_item(REQ_TARGET, tgt[k]));
    for (k = 0; k < qry.size(); k++) begin
      pending_items.push_back(mk_item(REQ_QUERY, qry[k]));
      // A late target character or an unknown request; both are ignored.
      if ($urandom_range(99) < 4)
        pending_items.push_back(mk_item($urandom_range(1) ? REQ_UNUSED : REQ_TARGET,
                                        CHAR_W'($urandom)));
    end
    pending_items.push_back(mk_item(REQ_END, '0));
    n_items += tgt.size() + qry.size() + 1;
  endtask

  // Mostly short pairs, a few long ones near the stored length limit.
  task automatic queue_random_phase(input int budget, input int ovf_kind);
    int n;
    int tn;
    int qn;
    int roll;
    n = 0;
    if (ovf_kind == OVF_TARGET) queue_pair(MAX_LEN + 2, 3, 1, 1'b0, n);
    else if (ovf_kind == OVF_QUERY) queue_pair(3, MAX_LEN + 2, 1, 1'b0, n);
    while (n < budget) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        tn = $urandom_range(MAX_LEN, 30);
        queue_pair(tn, tn + $urandom_range(2) - 1, $urandom_range(4), 1'b0, n);
      end else begin
        tn = $urandom_range(8);
        qn = tn + $urandom_range(4) - 2;
        if (qn < 0) qn = 0;
        queue_pair(tn, qn, $urandom_range(3), roll < 10, n);
      end
    end
  endtask

  // Stimulus and run sequencing.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 28;
    recv_idle_pct = 75;

    // Directed pairs at the reset bound of 2.
    // Both strings empty.
    pending_items.push_back(mk_item(REQ_END, '0));
    // Swap of the extreme code units.
    pending_items.push_back(mk_item(REQ_TARGET, 16'h0000));
    pending_items.push_back(mk_item(REQ_TARGET, 16'hFFFF));
    pending_items.push_back(mk_item(REQ_QUERY, 16'hFFFF));
    pending_items.push_back(mk_item(REQ_QUERY, 16'h0000));
    pending_items.push_back(mk_item(REQ_END, 16'hFFFF));
    // Unknown request.
    pending_items.push_back(mk_item(REQ_UNUSED, 16'hFFFF));
    // A target character after the first query character is ignored.
    pending_items.push_back(mk_item(REQ_TARGET, 16'h0061));
    pending_items.push_back(mk_item(REQ_QUERY, 16'h0061));
    pending_items.push_back(mk_item(REQ_TARGET, 16'h0062));
    pending_items.push_back(mk_item(REQ_END, '0));
    // Empty query whose length difference is beyond the bound.
    repeat (4) pending_items.push_back(mk_item(REQ_TARGET, 16'h0061));
    pending_items.push_back(mk_item(REQ_END, '0));
    // Equal lengths, but the row minimum climbs past the bound.
    pending_items.push_back(mk_item(REQ_TARGET, 16'h0061));
    pending_items.push_back(mk_item(REQ_TARGET, 16'h0062));
    pending_items.push_back(mk_item(REQ_TARGET, 16'h0063));
    pending_items.push_back(mk_item(REQ_QUERY, 16'h0078));
    pending_items.push_back(mk_item(REQ_QUERY, 16'h0079));
    pending_items.push_back(mk_item(REQ_QUERY, 16'h007A));
    pending_items.push_back(mk_item(REQ_END, '0));
    settle_idle();

    write_max_dist(4'd0);
    queue_random_phase(PHASE_ITEMS, OVF_TARGET);
    settle_idle();

    write_max_dist(4'd15);
    queue_random_phase(PHASE_ITEMS, OVF_NONE);
    settle_idle();

    // Sender and receiver swap their idle rates.
    send_idle_pct = 75;
    recv_idle_pct = 28;
    write_max_dist(4'd1);
    queue_random_phase(PHASE_ITEMS, OVF_QUERY);
    settle_idle();

    write_max_dist(4'd3);
    queue_random_phase(PHASE_ITEMS, OVF_NONE);
    settle_idle();

    // Back to back with no idling.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_max_dist(4'd7);
    queue_random_phase(PHASE_ITEMS, OVF_NONE);
    settle_idle();

    if (expected_distances.size() != 0)
      report_mismatch("results never returned", 0, expected_distances.size());
    if (mismatches == 0) begin
      $display("bounded_transposition_edit_distance_core regression: pass");
    end else begin
      $display("bounded_transposition_edit_distance_core regression: fail");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("bounded_transposition_edit_distance_core regression: fail");
    $finish;
  end

endmodule
